[sv/kwm_pkg.sv]
package kwm_pkg;

	// Default sizes of the run store
	localparam int MAX_RUNS_DEF  = 16;
	localparam int RUN_DEPTH_DEF = 64;

	// Field widths of the item channels and of the run-count register
	localparam int ACTION_W    = 2;
	localparam int RUN_FIELD_W = 4;
	localparam int DATA_W      = 32;
	localparam int STATUS_W    = 3;
	localparam int CFG_W       = 5;

	localparam logic [CFG_W-1:0] ACTIVE_RUNS_RST = 5'd16;

	// Request codes; the spare code is decoded as a take
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;

	// Response status codes
	localparam logic [STATUS_W-1:0] STS_APPENDED  = 3'd0;
	localparam logic [STATUS_W-1:0] STS_TAKEN     = 3'd1;
	localparam logic [STATUS_W-1:0] STS_EXHAUSTED = 3'd2;
	localparam logic [STATUS_W-1:0] STS_DROPPED   = 3'd3;
	localparam logic [STATUS_W-1:0] STS_CLEARED   = 3'd4;

endpackage

[sv/kwm_in_if.sv]
interface kwm_in_if;
	import kwm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic [RUN_FIELD_W-1:0]     run_index;
	logic signed [DATA_W-1:0]   value;

	modport source (output valid, output action, output run_index, output value, input ready);
	modport sink   (input valid, input action, input run_index, input value, output ready);

endinterface

[sv/kwm_out_if.sv]
interface kwm_out_if;
	import kwm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic signed [DATA_W-1:0]   out_value;
	logic [RUN_FIELD_W-1:0]     source_run;

	modport source (output valid, output status, output out_value, output source_run,
		input ready);
	modport sink   (input valid, input status, input out_value, input source_run,
		output ready);

endinterface

[sv/k_way_merge_engine_core.sv]
// k-way merge engine.
// Channels: req (sink) carries action, run_index and value; rsp (source) carries
// status, out_value and source_run; both move an item when valid and ready are high.
// cfg_wr_en / cfg_wr_data write active_runs (the number of runs k taking part).
// Each request item gives exactly one response item.
// Clear and append finish in the accept cycle; the response then passes through
// the result registers into the output register. A take scans the run heads one
// run per cycle through the single read port of the element memory; its response
// is formed when the scan of runs 0 to k-1 ends, k being active_runs limited to
// MAX_RUNS, and takes the same path to the output register.
// One request is worked on at a time; req.ready is high whenever no request is
// in progress, also while a finished response waits in the output register.
// If rsp is stalled, a second finished response waits inside until the output
// register frees, and no further request is taken meanwhile.
// arst_n empties every run, drops any response in flight and sets active_runs
// to 16. The element memory is not cleared; only written entries are ever read.
module k_way_merge_engine_core #(
	parameter int MAX_RUNS  = kwm_pkg::MAX_RUNS_DEF,
	parameter int RUN_DEPTH = kwm_pkg::RUN_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [kwm_pkg::CFG_W-1:0] cfg_wr_data,
	kwm_in_if.sink                    req,
	kwm_out_if.source                 rsp
);
	import kwm_pkg::*;

	localparam int RUN_W     = $clog2(MAX_RUNS);
	localparam int CNT_W     = $clog2(MAX_RUNS + 1);
	localparam int LEN_W     = $clog2(RUN_DEPTH + 1);
	localparam int MEM_DEPTH = MAX_RUNS * RUN_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESULT} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       active_runs_q;
	logic [LEN_W-1:0]       len_q [MAX_RUNS];
	logic [LEN_W-1:0]       pos_q [MAX_RUNS];
	logic [CNT_W-1:0]       cnt_q;

	// Scan pipeline: stage 1 holds the run whose head is being read
	logic                   live_s1;
	logic [RUN_W-1:0]       run_s1;
	logic [LEN_W-1:0]       pos_s1;

	logic                   found_q;
	logic [RUN_W-1:0]       best_q;
	logic [LEN_W-1:0]       best_pos_q;
	logic [DATA_W-1:0]      best_val_q;

	logic [STATUS_W-1:0]    res_status_q;
	logic [DATA_W-1:0]      res_value_q;
	logic [RUN_FIELD_W-1:0] res_run_q;

	logic                   rsp_valid_q;
	logic [STATUS_W-1:0]    rsp_status_q;
	logic [DATA_W-1:0]      rsp_value_q;
	logic [RUN_FIELD_W-1:0] rsp_run_q;

	logic [DATA_W-1:0]      mem [MEM_DEPTH];
	logic [DATA_W-1:0]      mem_rdata_q;

	logic [CNT_W-1:0]       k;
	logic [RUN_W-1:0]       rd_run;
	logic [LEN_W-1:0]       len_rd;
	logic [LEN_W-1:0]       pos_rd;
	logic [ADDR_W-1:0]      run_base;
	logic                   accept;
	logic                   append_ok;
	logic                   mem_we;
	logic                   issue;
	logic                   hit;
	logic                   finish;
	logic                   better;
	logic                   rsp_load;

	// Limit the run count to the runs that exist
	assign k = (32'(active_runs_q) > MAX_RUNS) ? CNT_W'(MAX_RUNS) : CNT_W'(active_runs_q);

	// One run-table read address: the scan counter while scanning, else the request
	assign rd_run   = (state_q == ST_SCAN) ? cnt_q[RUN_W-1:0] : RUN_W'(req.run_index);
	assign len_rd   = len_q[rd_run];
	assign pos_rd   = pos_q[rd_run];
	assign run_base = ADDR_W'(rd_run) * ADDR_W'(RUN_DEPTH);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign append_ok = (32'(req.run_index) < MAX_RUNS) && (len_rd < LEN_W'(RUN_DEPTH));
	assign mem_we    = accept && (req.action == ACT_APPEND) && append_ok;

	// Scan control: issue one head read per cycle, compare it in the next cycle
	assign issue  = (state_q == ST_SCAN) && (cnt_q < k);
	assign hit    = issue && (pos_rd < len_rd);
	assign finish = (state_q == ST_SCAN) && !issue && !live_s1;
	assign better = live_s1 && (!found_q || ($signed(mem_rdata_q) < $signed(best_val_q)));

	// Move a formed response into the output register once it is free
	assign rsp_load = (state_q == ST_RESULT) && (!rsp_valid_q || rsp.ready);

	// Element memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[run_base + ADDR_W'(len_rd)] <= req.value;
		end
		if (hit) begin
			mem_rdata_q <= mem[run_base + ADDR_W'(pos_rd)];
		end
	end

	// Sequencer, run tables and response registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			active_runs_q <= ACTIVE_RUNS_RST;
			cnt_q         <= '0;
			live_s1       <= 1'b0;
			found_q       <= 1'b0;
			rsp_valid_q   <= 1'b0;
			for (int r = 0; r < MAX_RUNS; r++) begin
				len_q[r] <= '0;
				pos_q[r] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				active_runs_q <= cfg_wr_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_value_q <= '0;
						res_run_q   <= '0;
						case (req.action)
							ACT_CLEAR: begin
								for (int r = 0; r < MAX_RUNS; r++) begin
									len_q[r] <= '0;
									pos_q[r] <= '0;
								end
								res_status_q <= STS_CLEARED;
								state_q      <= ST_RESULT;
							end
							ACT_APPEND: begin
								if (append_ok) begin
									len_q[rd_run] <= len_rd + LEN_W'(1);
									res_status_q  <= STS_APPENDED;
								end else begin
									res_status_q  <= STS_DROPPED;
								end
								state_q <= ST_RESULT;
							end
							default: begin
								// take; the spare code takes as well
								cnt_q   <= '0;
								found_q <= 1'b0;
								live_s1 <= 1'b0;
								state_q <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					live_s1 <= hit;
					run_s1  <= rd_run;
					pos_s1  <= pos_rd;
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					// Keep the smallest head; ties keep the earlier run
					if (better) begin
						found_q    <= 1'b1;
						best_q     <= run_s1;
						best_pos_q <= pos_s1;
						best_val_q <= mem_rdata_q;
					end
					if (finish) begin
						if (found_q) begin
							pos_q[best_q] <= best_pos_q + LEN_W'(1);
							res_status_q  <= STS_TAKEN;
							res_value_q   <= best_val_q;
							res_run_q     <= RUN_FIELD_W'(best_q);
						end else begin
							res_status_q  <= STS_EXHAUSTED;
							res_value_q   <= '0;
							res_run_q     <= '0;
						end
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					// Hold until the output register is free
					if (rsp_load) begin
						rsp_status_q <= res_status_q;
						rsp_value_q  <= res_value_q;
						rsp_run_q    <= res_run_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.out_value  = rsp_value_q;
	assign rsp.source_run = rsp_run_q;

	// The scan never runs past the active runs
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= k))
		else $error("scan counter beyond active runs");

	// A taken head always lies below its run's length
	a_take_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && found_q) |-> (best_pos_q < len_q[best_q]))
		else $error("take beyond end of run");

	// Only a take carries a value and a source run
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_status_q != STS_TAKEN)) |->
		((rsp_value_q == '0) && (rsp_run_q == '0)))
		else $error("nonzero fields on a response that is not a take");

	// An accepted request closes the input until its response is formed
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("second request taken while one is in progress");

endmodule
